[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every rising clock edge.
`define ALC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/alc_pkg.sv]
package alc_pkg;

  localparam int unsigned MaxLockLevel = 4;
  localparam int unsigned ModeCount    = 17;

  // Remaining milliseconds are turned into whole seconds, rounded up, by a
  // multiplication with a scaled reciprocal of one thousand.
  localparam logic [9:0]  MsRound  = 10'd999;
  localparam logic [24:0] SecRecip = 25'd17179870;
  localparam int unsigned SecShift = 34;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_CARD  = 2'd1,
    CMD_ERROR = 2'd2,
    CMD_KEY   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CARD_UNKNOWN    = 2'd0,
    CARD_REGISTERED = 2'd1,
    CARD_ADMIN      = 2'd2,
    CARD_INVALID    = 2'd3
  } card_e;

  typedef enum logic [1:0] {
    TREQ_NONE = 2'd0,
    TREQ_ADD  = 2'd1,
    TREQ_DEL  = 2'd2,
    TREQ_SET  = 2'd3
  } treq_e;

  typedef enum logic [2:0] {
    CFG_LOCK_BASE  = 3'd0,
    CFG_SPAM_WIN   = 3'd1,
    CFG_MAX_DENY   = 3'd2,
    CFG_LONG_WAIT  = 3'd3,
    CFG_SHORT_WAIT = 3'd4
  } cfg_idx_e;

  localparam logic [3:0] KeyOne   = 4'd1;
  localparam logic [3:0] KeyTwo   = 4'd2;
  localparam logic [3:0] KeyThree = 4'd3;
  localparam logic [3:0] KeyHash  = 4'd11;

  // Controller modes, one-hot. The bit position is the mode code on the bus.
  typedef enum logic [16:0] {
    M_IDLE     = 17'h00001,
    M_PASS     = 17'h00002,
    M_ADMIN    = 17'h00004,
    M_ALLOW    = 17'h00008,
    M_DENY     = 17'h00010,
    M_LOCK     = 17'h00020,
    M_ADD      = 17'h00040,
    M_DEL      = 17'h00080,
    M_CHG      = 17'h00100,
    M_ADDED    = 17'h00200,
    M_EXISTS   = 17'h00400,
    M_DELETED  = 17'h00800,
    M_NOTFOUND = 17'h01000,
    M_PROTECT  = 17'h02000,
    M_CHANGED  = 17'h04000,
    M_CHGDENY  = 17'h08000,
    M_ERR      = 17'h10000
  } mode_e;

  typedef struct packed {
    logic [15:0] lock_base_ms;
    logic [19:0] spam_window_ms;
    logic [3:0]  max_denials;
    logic [19:0] long_wait_ms;
    logic [19:0] short_wait_ms;
  } cfg_t;

  typedef struct packed {
    cmd_e       command;
    logic [1:0] card_class;
    logic [3:0] key_code;
    logic       password_ok;
  } item_t;

  typedef struct packed {
    logic [4:0]  mode;
    logic        door_open;
    logic        buzzer_active;
    treq_e       table_request;
    logic [22:0] lock_ms_left;
    logic [2:0]  level_now;
  } res_t;

  function automatic logic [4:0] mode_code(mode_e m);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < ModeCount; i++) begin
      if (m[i]) begin
        c = c | 5'(i);
      end
    end
    return c;
  endfunction

endpackage

[rtl/access_lock_controller.sv]
// A word accepted on the slave side is held in the input register and then
// processed into the result register, whose word is offered on the master
// side, stalling there while a result is not taken. Throughput: one word
// per cycle while results are taken; the result register frees as it is taken.
// Reset (rst_ni low, asynchronous): mode idle, door closed, buzzer off, all
// timers, counters and the lock level cleared, config registers at defaults.
`include "assert_macros.svh"

module access_lock_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_wdata_i,
  // Event stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // card_class[1:0], key_code[5:2], password_ok[6]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // mode[4:0], door_open[5], buzzer_active[6],
                                     // table_request[8:7], lock_seconds_left[21:9],
                                     // level_now[24:22]
);
  import alc_pkg::*;

  cfg_t  cfg;
  item_t in_q, in_d;
  logic  in_valid_q, in_valid_d;
  res_t  res, out_q;
  logic  out_valid_q, out_valid_d;
  logic  advance;
  logic [12:0] secs;

  alc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The word in the input register is processed when the result register
  // is empty or its word is being taken in this cycle. The state update and
  // the result capture happen on the same edge, so the controller state
  // always reflects every word that has reached the result register.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_d.command     = cmd_e'(s_axis_tuser);
    in_d.card_class  = s_axis_tdata[1:0];
    in_d.key_code    = s_axis_tdata[5:2];
    in_d.password_ok = s_axis_tdata[6];
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  alc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (advance),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  // The remaining lockout time is held in milliseconds and converted to
  // seconds behind the result register.
  alc_sec u_sec (
    .ms_i  (out_q.lock_ms_left),
    .sec_o (secs)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.level_now, secs, out_q.table_request,
                          out_q.buzzer_active, out_q.door_open, out_q.mode};

  `ALC_ASSERT(a_no_overwrite, !(advance && out_valid_q && !m_axis_tready), "result overwritten")
  `ALC_ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q, "pending word lost")
  `ALC_ASSERT_NEXT(a_out_set, advance, out_valid_q, "processed word not presented")

endmodule

[rtl/alc_cfg_regs.sv]
module alc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [19:0]   cfg_wdata_i,
  output alc_pkg::cfg_t cfg_o
);
  import alc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOCK_BASE:  cfg_d.lock_base_ms   = cfg_wdata_i[15:0];
        CFG_SPAM_WIN:   cfg_d.spam_window_ms = cfg_wdata_i;
        CFG_MAX_DENY:   cfg_d.max_denials    = cfg_wdata_i[3:0];
        CFG_LONG_WAIT:  cfg_d.long_wait_ms   = cfg_wdata_i;
        CFG_SHORT_WAIT: cfg_d.short_wait_ms  = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lock_base_ms   <= 16'd3000;
      cfg_q.spam_window_ms <= 20'd10000;
      cfg_q.max_denials    <= 4'd3;
      cfg_q.long_wait_ms   <= 20'd10000;
      cfg_q.short_wait_ms  <= 20'd3000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/alc_core.sv]
`include "assert_macros.svh"

module alc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  alc_pkg::cfg_t  cfg_i,
  input  logic           adv_i,
  input  alc_pkg::item_t item_i,
  output alc_pkg::res_t  res_o
);
  import alc_pkg::*;

  mode_e       state_q, state_d, nxt;
  logic        door_q, door_d;
  logic        buzz_q, buzz_d;
  logic [3:0]  dcnt_q, dcnt_d;
  logic [31:0] dstart_q, dstart_d;
  logic [31:0] now_q, now_d;
  logic [31:0] wait_q, wait_d;
  logic [2:0]  level_q, level_d;
  logic [22:0] len_q, len_d;

  card_e       cls;
  treq_e       req;
  logic [31:0] elapsed, elapsed_fin;
  logic [31:0] dstart_new;
  logic [3:0]  dcnt_base, dcnt_new;
  logic [2:0]  level_up;
  logic        long_exp, short_exp;

  // An out-of-range card class counts as an unknown card.
  assign cls = (card_e'(item_i.card_class) == CARD_INVALID) ? CARD_UNKNOWN
                                                           : card_e'(item_i.card_class);

  assign now_d     = now_q + 32'(item_i.command == CMD_TICK);
  assign elapsed   = now_d - wait_q;
  assign long_exp  = elapsed > {12'd0, cfg_i.long_wait_ms};
  assign short_exp = elapsed > {12'd0, cfg_i.short_wait_ms};

  // Denial bookkeeping for an unknown card seen in idle.
  assign dstart_new = (dcnt_q == 4'd0) ? now_d : dstart_q;
  assign dcnt_base  = ((now_d - dstart_new) > {12'd0, cfg_i.spam_window_ms}) ? 4'd0 : dcnt_q;
  assign dcnt_new   = dcnt_base + 4'd1;

  always_comb begin
    nxt      = state_q;
    wait_d   = wait_q;
    dcnt_d   = dcnt_q;
    dstart_d = dstart_q;
    level_d  = level_q;
    len_d    = len_q;
    door_d   = door_q;
    buzz_d   = buzz_q;
    req      = TREQ_NONE;
    level_up = '0;

    case (state_q)
      M_IDLE: begin
        if (item_i.command == CMD_CARD) begin
          if (cls == CARD_ADMIN || cls == CARD_REGISTERED) begin
            dcnt_d  = '0;
            level_d = '0;
            nxt     = (cls == CARD_ADMIN) ? M_ADMIN : M_ALLOW;
          end else begin
            dstart_d = dstart_new;
            if (dcnt_new >= cfg_i.max_denials) begin
              dcnt_d = '0;
              nxt    = M_LOCK;
            end else begin
              dcnt_d = dcnt_new;
              nxt    = M_DENY;
            end
          end
          wait_d = now_d;
        end else if (item_i.command == CMD_ERROR) begin
          nxt = M_ERR;
        end else if (item_i.command == CMD_KEY && item_i.key_code == KeyHash) begin
          nxt = M_PASS;
        end
      end
      M_PASS: begin
        if (item_i.command == CMD_KEY && item_i.key_code == KeyHash) begin
          if (item_i.password_ok) begin
            level_d = '0;
            nxt     = M_ALLOW;
          end else begin
            nxt = M_DENY;
          end
          wait_d = now_d;
        end
      end
      M_ADMIN: begin
        // A menu key wins over a timeout seen on the same event.
        if (long_exp) begin
          nxt = M_IDLE;
        end
        if (item_i.command == CMD_KEY && (item_i.key_code inside {[KeyOne:KeyThree]})) begin
          nxt    = (item_i.key_code == KeyOne) ? M_ADD :
                   (item_i.key_code == KeyTwo) ? M_DEL : M_CHG;
          wait_d = now_d;
        end
      end
      M_LOCK: begin
        if (elapsed >= {9'd0, len_q}) begin
          nxt = M_IDLE;
        end
      end
      M_ADD, M_DEL, M_CHG: begin
        if (long_exp) begin
          nxt = M_IDLE;
        end else if (item_i.command == CMD_ERROR) begin
          nxt = M_ERR;
        end else if (item_i.command == CMD_CARD) begin
          if (state_q == M_ADD) begin
            if (cls == CARD_UNKNOWN) begin
              nxt = M_ADDED;
              req = TREQ_ADD;
            end else begin
              nxt = M_EXISTS;
            end
          end else if (state_q == M_DEL) begin
            if (cls == CARD_REGISTERED) begin
              nxt = M_DELETED;
              req = TREQ_DEL;
            end else begin
              nxt = (cls == CARD_UNKNOWN) ? M_NOTFOUND : M_PROTECT;
            end
          end else begin
            if (cls == CARD_UNKNOWN) begin
              nxt = M_CHANGED;
              req = TREQ_SET;
            end else begin
              nxt = M_CHGDENY;
            end
            wait_d = now_d;
          end
        end
      end
      M_ERR: begin
        if (item_i.command != CMD_ERROR) begin
          nxt = M_IDLE;
        end
      end
      default: begin
        // Result message modes fall back to idle after the short wait.
        if (short_exp) begin
          nxt = M_IDLE;
        end
      end
    endcase

    // Entry actions run only on a change of mode.
    if (nxt != state_q) begin
      case (nxt)
        M_IDLE: begin
          door_d = 1'b0;
          buzz_d = 1'b0;
        end
        M_ADMIN, M_ALLOW: begin
          door_d = 1'b1;
        end
        M_DENY: begin
          buzz_d = 1'b1;
        end
        M_ERR: begin
          door_d = 1'b0;
          buzz_d = 1'b1;
        end
        M_LOCK: begin
          door_d   = 1'b0;
          buzz_d   = 1'b1;
          level_up = (level_d < 3'(MaxLockLevel)) ? level_d + 3'd1 : level_d;
          if (level_up == 3'd0) begin
            level_up = 3'd1;
          end
          level_d = level_up;
          len_d   = 23'({7'd0, cfg_i.lock_base_ms} << (level_up - 3'd1));
          wait_d  = now_d;
        end
        default: begin
          door_d = door_q;
        end
      endcase
    end
    state_d = nxt;
  end

  assign elapsed_fin = now_d - wait_d;

  always_comb begin
    res_o.mode          = mode_code(state_d);
    res_o.door_open     = door_d;
    res_o.buzzer_active = buzz_d;
    res_o.table_request = req;
    res_o.level_now     = level_d;
    if (state_d == M_LOCK && elapsed_fin < {9'd0, len_d}) begin
      res_o.lock_ms_left = len_d - elapsed_fin[22:0];
    end else begin
      res_o.lock_ms_left = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= M_IDLE;
      door_q   <= 1'b0;
      buzz_q   <= 1'b0;
      dcnt_q   <= '0;
      dstart_q <= '0;
      now_q    <= '0;
      wait_q   <= '0;
      level_q  <= '0;
      len_q    <= '0;
    end else if (adv_i) begin
      state_q  <= state_d;
      door_q   <= door_d;
      buzz_q   <= buzz_d;
      dcnt_q   <= dcnt_d;
      dstart_q <= dstart_d;
      now_q    <= now_d;
      wait_q   <= wait_d;
      level_q  <= level_d;
      len_q    <= len_d;
    end
  end

  `ALC_ASSERT(a_level_max, level_q <= 3'(MaxLockLevel), "lock level above its maximum")
  `ALC_ASSERT(a_lock_safe, state_q != M_LOCK || (buzz_q && !door_q), "lockout with door open")
  `ALC_ASSERT(a_err_safe, state_q != M_ERR || (buzz_q && !door_q), "error mode with door open")

endmodule

[rtl/alc_sec.sv]
module alc_sec (
  input  logic [22:0] ms_i,
  output logic [12:0] sec_o
);
  import alc_pkg::*;

  logic [23:0] ms_up;
  logic [48:0] prod;

  // ceil(ms / 1000) as (ms + 999) times a scaled reciprocal; exact below 2^24.
  assign ms_up = {1'b0, ms_i} + 24'(MsRound);
  assign prod  = 49'(ms_up) * 49'(SecRecip);
  assign sec_o = prod[SecShift+12:SecShift];

endmodule
